>>> design/etpc_pkg.sv
// ----------------------------------------------------------------------------
// etpc_pkg
// Shared types, constants and helpers of the encoder turn pulse controller.
// ----------------------------------------------------------------------------
package etpc_pkg;

	localparam int COUNT_W  = 32;               // encoder count
	localparam int COEF_W   = 24;               // per-wheel coefficient, Q8.16
	localparam int PROD_W   = COUNT_W + COEF_W; // one wheel's share, Q40.16
	localparam int HEAD_W   = PROD_W + 2;       // exact sum of three shares
	localparam int ERR_W    = HEAD_W + 1;       // target minus heading
	localparam int OUT_W    = 32;               // saturated heading port
	localparam int TIME_W   = 63;               // microsecond time
	localparam int ROUTE_W  = 8;
	localparam int DRIVE_W  = 2;
	localparam int CFG_IDX_W = 2;

	// Pulse phase is only needed while the turn is younger than the timeout,
	// so 24 bits of elapsed time cover it.
	localparam int PHASE_W     = 24;
	localparam int REM_W       = PHASE_W + 1;
	localparam int RECIP       = 21474;         // floor(2^32 / 200000)
	localparam int RECIP_W     = 15;
	localparam int RECIP_SHIFT = 32;
	localparam int QPROD_W     = PHASE_W + RECIP_W;
	localparam int Q_W         = QPROD_W - RECIP_SHIFT;

	localparam int TARGET_Q16  = 30 * 65536;
	localparam int WINDOW_Q16  = 2 * 65536;
	localparam int BIG_ERR_Q16 = 10 * 65536;

	localparam int SETTLE_US       = 300000;
	localparam int TIMEOUT_US      = 10000000;
	localparam int PULSE_PERIOD_US = 200000;
	localparam int PULSE_LONG_US   = 60000;
	localparam int PULSE_SHORT_US  = 40000;

	localparam logic [CFG_IDX_W-1:0] CFG_COEF_A = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_COEF_B = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_COEF_D = 2'd2;

	localparam logic ACT_BEGIN = 1'b0;
	localparam logic ACT_STEP  = 1'b1;

	localparam logic [ROUTE_W-1:0] ROUTE_POS = 8'd1;
	localparam logic [ROUTE_W-1:0] ROUTE_NEG = 8'd2;

	localparam logic [DRIVE_W-1:0] DRIVE_OFF = 2'b00;
	localparam logic [DRIVE_W-1:0] DRIVE_POS = 2'b01;
	localparam logic [DRIVE_W-1:0] DRIVE_NEG = 2'b11;

	// Lane control, common to all three wheels
	typedef struct packed {
		logic accept;      // item taken this cycle
		logic begin_item;  // that item begins a turn
		logic take;        // first stage loads
	} lane_ctl_t;

	// Per-item facts resolved at the first stage
	typedef struct packed {
		logic               is_step;
		logic [ROUTE_W-1:0] route;
		logic               settled;
		logic               timed_out;
		logic [PHASE_W-1:0] since_begin;
	} item_info_t;

	// Pipeline moves between stage two and the result register
	typedef struct packed {
		logic take2;
		logic load_out;
	} merge_ctl_t;

	// Start of the pulse period that holds a given quotient
	function automatic logic [REM_W-1:0] period_base(input logic [Q_W-1:0] q);
		return REM_W'(q) * REM_W'(PULSE_PERIOD_US);
	endfunction

endpackage

>>> design/etpc_lane.sv
// ----------------------------------------------------------------------------
// etpc_lane
// One wheel: holds start and last count, forms the wrapped count delta
// times the wheel coefficient, and flags a count change.
// ----------------------------------------------------------------------------
module etpc_lane (
	input  logic                               clk,
	input  logic                               arst_n,
	input  etpc_pkg::lane_ctl_t                ctl,
	input  logic [etpc_pkg::COUNT_W-1:0]       count,
	input  logic signed [etpc_pkg::COEF_W-1:0] coef,
	output logic                               changed,
	output logic signed [etpc_pkg::PROD_W-1:0] prod_s1
);
	import etpc_pkg::*;

	logic [COUNT_W-1:0]       start_q;
	logic [COUNT_W-1:0]       last_q;
	logic signed [COUNT_W-1:0] delta;
	logic signed [PROD_W-1:0]  prod;

	assign delta   = signed'(count - start_q);
	assign prod    = delta * coef;
	assign changed = (count != last_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0;
			last_q  <= '0;
		end else if (ctl.accept) begin
			if (ctl.begin_item) begin
				start_q <= count;
			end
			last_q <= count;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.take) begin
			prod_s1 <= prod;
		end
	end

endmodule

>>> design/etpc_merge.sv
// ----------------------------------------------------------------------------
// etpc_merge
// Sums the lane shares into the heading, works out the pulse phase, and
// runs the turn decision that drives the result register.
// ----------------------------------------------------------------------------
module etpc_merge (
	input  logic                                clk,
	input  logic                                arst_n,
	input  etpc_pkg::merge_ctl_t                ctl,
	input  etpc_pkg::item_info_t                info_s1,
	input  logic signed [etpc_pkg::PROD_W-1:0]  prod_a_s1,
	input  logic signed [etpc_pkg::PROD_W-1:0]  prod_b_s1,
	input  logic signed [etpc_pkg::PROD_W-1:0]  prod_d_s1,
	output logic [etpc_pkg::DRIVE_W-1:0]        drive,
	output logic                                turn_done,
	output logic                                turn_failed,
	output logic [etpc_pkg::OUT_W-1:0]          heading_q16
);
	import etpc_pkg::*;

	localparam logic [OUT_W-1:0] HEAD_MAX = {1'b0, {(OUT_W-1){1'b1}}};
	localparam logic [OUT_W-1:0] HEAD_MIN = {1'b1, {(OUT_W-1){1'b0}}};

	item_info_t              info_s2;
	logic signed [HEAD_W-1:0] head_s2;
	logic [Q_W-1:0]          q_s2;

	logic signed [HEAD_W-1:0] head_sum;
	logic [QPROD_W-1:0]      qprod;

	logic signed [ERR_W-1:0] target;
	logic signed [ERR_W-1:0] err;
	logic signed [ERR_W-1:0] aerr;
	logic                    in_window;
	logic                    big_err;
	logic [REM_W-1:0]        rem_est;
	logic [REM_W-1:0]        phase;
	logic [REM_W-1:0]        limit;
	logic                    pulse_on;
	logic [OUT_W-1:0]        head_sat;

	logic running_q, done_q, failed_q, tneg_q;
	logic running_n, done_n, failed_n, tneg_n;
	logic [DRIVE_W-1:0] drive_n;
	logic [OUT_W-1:0]   head_n;

	logic [DRIVE_W-1:0] drive_q;
	logic               turn_done_q;
	logic               turn_failed_q;
	logic [OUT_W-1:0]   heading_q;

	// stage two: exact heading sum and period quotient estimate
	assign head_sum = HEAD_W'(prod_a_s1) + HEAD_W'(prod_b_s1) + HEAD_W'(prod_d_s1);
	assign qprod    = QPROD_W'(info_s1.since_begin) * QPROD_W'(RECIP);

	always_ff @(posedge clk) begin
		if (ctl.take2) begin
			info_s2 <= info_s1;
			head_s2 <= head_sum;
			q_s2    <= qprod[QPROD_W-1:RECIP_SHIFT];
		end
	end

	// error against target
	assign target    = tneg_q ? -ERR_W'(TARGET_Q16) : ERR_W'(TARGET_Q16);
	assign err       = target - ERR_W'(head_s2);
	assign aerr      = err[ERR_W-1] ? -err : err;
	assign in_window = (aerr <= ERR_W'(WINDOW_Q16));
	assign big_err   = (aerr > ERR_W'(BIG_ERR_Q16));

	// quotient estimate is exact or one short: one correction step
	assign rem_est  = {1'b0, info_s2.since_begin} - period_base(q_s2);
	assign phase    = (rem_est >= REM_W'(PULSE_PERIOD_US)) ?
	                  rem_est - REM_W'(PULSE_PERIOD_US) : rem_est;
	assign limit    = big_err ? REM_W'(PULSE_LONG_US) : REM_W'(PULSE_SHORT_US);
	assign pulse_on = (phase < limit);

	always_comb begin
		if (head_s2[HEAD_W-1:OUT_W-1] == '0 || head_s2[HEAD_W-1:OUT_W-1] == '1) begin
			head_sat = head_s2[OUT_W-1:0];
		end else begin
			head_sat = head_s2[HEAD_W-1] ? HEAD_MIN : HEAD_MAX;
		end
	end

	always_comb begin
		running_n = running_q;
		done_n    = done_q;
		failed_n  = failed_q;
		tneg_n    = tneg_q;
		drive_n   = DRIVE_OFF;
		head_n    = head_sat;
		if (!info_s2.is_step) begin
			running_n = 1'b1;
			tneg_n    = (info_s2.route != ROUTE_POS);
			done_n    = 1'b0;
			failed_n  = (info_s2.route != ROUTE_POS) && (info_s2.route != ROUTE_NEG);
			head_n    = '0;
		end else if (!running_q) begin
			head_n = '0;
		end else if (!done_q && !failed_q) begin
			if (in_window && info_s2.settled) begin
				done_n = 1'b1;
			end else if (info_s2.timed_out) begin
				failed_n = 1'b1;
			end else if (!in_window && pulse_on) begin
				drive_n = err[ERR_W-1] ? DRIVE_NEG : DRIVE_POS;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= 1'b0;
			done_q    <= 1'b0;
			failed_q  <= 1'b0;
			tneg_q    <= 1'b0;
		end else if (ctl.load_out) begin
			running_q <= running_n;
			done_q    <= done_n;
			failed_q  <= failed_n;
			tneg_q    <= tneg_n;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_out) begin
			drive_q       <= drive_n;
			turn_done_q   <= done_n;
			turn_failed_q <= failed_n;
			heading_q     <= head_n;
		end
	end

	assign drive       = drive_q;
	assign turn_done   = turn_done_q;
	assign turn_failed = turn_failed_q;
	assign heading_q16 = heading_q;

	a_done_failed_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(done_q && failed_q))
		else $error("turn both done and failed");

	a_flags_need_run: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q || failed_q) |-> running_q)
		else $error("turn flag set without a started turn");

	a_drive_only_active: assert property (@(posedge clk) disable iff (!arst_n)
		$past(ctl.load_out) && drive_q != DRIVE_OFF |-> !turn_done_q && !turn_failed_q)
		else $error("drive pulse on a finished turn");

endmodule

>>> design/encoder_turn_pulse_controller_top.sv
// ----------------------------------------------------------------------------
// encoder_turn_pulse_controller_top
// Starts +30 / -30 degree turns, estimates heading from three wheel encoders
// and pulses the motor toward the target until settled or timed out.
//
//   channel | handshake            | payload
//   --------+----------------------+-------------------------------------------
//   in      | in_valid / in_stall  | action route count_a count_b count_d now_us
//   out     | out_valid / out_stall| drive turn_done turn_failed heading_q16
//   cfg     | cfg_valid / cfg_ready| cfg_index cfg_data (coefficients A, B, D)
//
// One item per cycle sustained while out_stall is low; a result passes
// through the lane multiply stage, the heading sum stage and the result
// register. The three lane multipliers set the first stage's depth.
// Stages hold under out_stall and empty ones still fill, so input is taken
// while a result waits and a stage is free. Reset clears the coefficients
// and puts the block in the not-started state; cfg_ready is always high.
// ----------------------------------------------------------------------------
module encoder_turn_pulse_controller_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic                                 action,
	input  logic [etpc_pkg::ROUTE_W-1:0]         route,
	input  logic signed [etpc_pkg::COUNT_W-1:0]  count_a,
	input  logic signed [etpc_pkg::COUNT_W-1:0]  count_b,
	input  logic signed [etpc_pkg::COUNT_W-1:0]  count_d,
	input  logic [etpc_pkg::TIME_W-1:0]          now_us,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [etpc_pkg::DRIVE_W-1:0]  drive,
	output logic                                 turn_done,
	output logic                                 turn_failed,
	output logic signed [etpc_pkg::OUT_W-1:0]    heading_q16,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [etpc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [etpc_pkg::COEF_W-1:0]          cfg_data
);
	import etpc_pkg::*;

	logic signed [COEF_W-1:0] coef_a_q, coef_b_q, coef_d_q;
	logic [TIME_W-1:0]        start_time_q;
	logic [TIME_W-1:0]        still_time_q;

	logic v1_q, v2_q, out_valid_q;
	logic take1, take2, load_out, accept;
	logic chg_a, chg_b, chg_d, any_chg;
	logic [TIME_W-1:0] since_begin;
	logic [TIME_W-1:0] since_still;

	lane_ctl_t  lane_ctl;
	merge_ctl_t merge_ctl;
	item_info_t info_c, info_s1;

	logic signed [PROD_W-1:0] prod_a_s1, prod_b_s1, prod_d_s1;
	logic [DRIVE_W-1:0]       drive_raw;
	logic [OUT_W-1:0]         heading_raw;

	// pipeline flow: a stage loads when it is empty or its item moves on
	assign load_out = v2_q && (!out_valid_q || !out_stall);
	assign take2    = !v2_q || load_out;
	assign take1    = !v1_q || take2;
	assign accept   = in_valid && take1;
	assign in_stall = !take1;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q        <= 1'b0;
			v2_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (take1) begin
				v1_q <= in_valid;
			end
			if (take2) begin
				v2_q <= v1_q;
			end
			if (!out_valid_q || !out_stall) begin
				out_valid_q <= v2_q;
			end
		end
	end

	// configuration
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_a_q <= '0;
			coef_b_q <= '0;
			coef_d_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_COEF_A: coef_a_q <= signed'(cfg_data);
				CFG_COEF_B: coef_b_q <= signed'(cfg_data);
				CFG_COEF_D: coef_d_q <= signed'(cfg_data);
				default: ;
			endcase
		end
	end

	// wheel lanes
	assign lane_ctl.accept     = accept;
	assign lane_ctl.begin_item = (action == ACT_BEGIN);
	assign lane_ctl.take       = take1;

	etpc_lane u_lane_a (
		.clk(clk), .arst_n(arst_n), .ctl(lane_ctl), .count(count_a),
		.coef(coef_a_q), .changed(chg_a), .prod_s1(prod_a_s1)
	);

	etpc_lane u_lane_b (
		.clk(clk), .arst_n(arst_n), .ctl(lane_ctl), .count(count_b),
		.coef(coef_b_q), .changed(chg_b), .prod_s1(prod_b_s1)
	);

	etpc_lane u_lane_d (
		.clk(clk), .arst_n(arst_n), .ctl(lane_ctl), .count(count_d),
		.coef(coef_d_q), .changed(chg_d), .prod_s1(prod_d_s1)
	);

	assign any_chg = chg_a || chg_b || chg_d;

	// elapsed times; a step that moved any wheel restarts the settle window
	assign since_begin = (now_us >= start_time_q) ? now_us - start_time_q : '0;
	assign since_still = (now_us >= still_time_q) ? now_us - still_time_q : '0;

	assign info_c.is_step     = (action == ACT_STEP);
	assign info_c.route       = route;
	assign info_c.settled     = !any_chg && (since_still >= TIME_W'(SETTLE_US));
	assign info_c.timed_out   = (since_begin >= TIME_W'(TIMEOUT_US));
	assign info_c.since_begin = since_begin[PHASE_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_time_q <= '0;
			still_time_q <= '0;
		end else if (accept) begin
			if (action == ACT_BEGIN) begin
				start_time_q <= now_us;
				still_time_q <= now_us;
			end else if (any_chg) begin
				still_time_q <= now_us;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take1) begin
			info_s1 <= info_c;
		end
	end

	assign merge_ctl.take2    = take2;
	assign merge_ctl.load_out = load_out;

	etpc_merge u_merge (
		.clk(clk), .arst_n(arst_n), .ctl(merge_ctl), .info_s1(info_s1),
		.prod_a_s1(prod_a_s1), .prod_b_s1(prod_b_s1), .prod_d_s1(prod_d_s1),
		.drive(drive_raw), .turn_done(turn_done), .turn_failed(turn_failed),
		.heading_q16(heading_raw)
	);

	assign drive       = signed'(drive_raw);
	assign heading_q16 = signed'(heading_raw);

	a_empty_takes: assert property (@(posedge clk) disable iff (!arst_n)
		!v1_q |-> !in_stall)
		else $error("input held off with an empty first stage");

	a_accept_fills: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> v1_q)
		else $error("accepted item lost before the first stage");

	a_out_from_s2: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(v2_q))
		else $error("result shown without a stage two item");

endmodule
